FILE: hw/rtl/atpll_pkg.sv
// Shared types, constants and fixed-point helpers of the angle tracking PLL.
package atpll_pkg;

    localparam int FRAC_BITS = 16;

    localparam logic signed [31:0] HALF_TURN = 32'sd205888;
    localparam logic signed [31:0] FULL_TURN = 32'sd411776;

    // Register indexes, word aligned on the configuration port
    localparam logic [1:0] REG_PROP_GAIN     = 2'd0;
    localparam logic [1:0] REG_INTEGRAL_GAIN = 2'd1;
    localparam logic [1:0] REG_TIME_STEP     = 2'd2;
    localparam logic [1:0] REG_SPEED_LIMIT   = 2'd3;

    localparam logic [30:0] SPEED_LIMIT_RESET = 31'h7FFF_FFFF;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIFF,
        S_WRAP_ERR,
        S_MUL_KP,
        S_SUM_SPD,
        S_MUL_PH,
        S_SUM_PH,
        S_WRAP_PH,
        S_MUL_KI,
        S_MUL_LO,
        S_MUL_HI,
        S_FORM_INC,
        S_SUM_INC,
        S_CLIP
    } atpll_state_t;

    // Saturate a 33-bit sum to the signed 32-bit range
    function automatic logic signed [31:0] sat32(input logic signed [32:0] s);
        logic signed [31:0] r;
        if (s[32] != s[31]) begin
            r = s[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else begin
            r = s[31:0];
        end
        return r;
    endfunction

    // Add or subtract one full turn at most once
    function automatic logic signed [31:0] wrap_turn(input logic signed [31:0] a);
        logic signed [31:0] r;
        if (a >= HALF_TURN) begin
            r = a - FULL_TURN;
        end else if (a < -HALF_TURN) begin
            r = a + FULL_TURN;
        end else begin
            r = a;
        end
        return r;
    endfunction

endpackage

FILE: hw/rtl/angle_tracking_pll.sv
// Angle tracking PLL with PI loop filter on one shared multiplier, Q16.16.
//
//  channel   | direction | handshake          | contents
//  ----------+-----------+--------------------+--------------------------------------
//  s_        | in        | s_tvalid/s_tready  | measured_phase
//  m_        | out       | m_tvalid/m_tready  | phase_estimate, speed_estimate
//  APB       | in/out    | psel/penable       | prop_gain, integral_gain, time_step,
//            |           |                    | speed_limit at byte addresses 0,4,8,12
//
// An item is accepted in the idle state and then runs 13 sequencer steps, five of
// them through the single 33x32 multiplier; no new item is taken until it is done.
// The final step waits while the previous result still sits in the output
// register, so a stalled m_tready stretches the item by the stall.
// aresetn is synchronous, active low; it clears tracked phase and speed and
// returns the registers to their reset values.
module angle_tracking_pll
    import atpll_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [18:0] measured_phase, [23:19] zero

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // [18:0] phase_estimate, [50:19] speed_estimate, [55:51] zero

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    atpll_state_t state_reg, state_next;

    logic [30:0] prop_gain_reg;
    logic [30:0] integral_gain_reg;
    logic [16:0] time_step_reg;
    logic [30:0] speed_limit_reg;

    logic signed [18:0] meas_reg;
    logic signed [31:0] acc_reg, acc_next;
    logic signed [31:0] err_reg, err_next;
    logic signed [63:0] prod_reg, prod_next;
    logic [47:0]        lo_reg, lo_next;
    logic signed [31:0] phase_reg, phase_next;
    logic signed [31:0] speed_reg, speed_next;
    logic [18:0]        out_phase_reg, out_phase_next;
    logic signed [31:0] out_speed_reg, out_speed_next;
    logic               m_valid_reg, m_valid_next;

    logic signed [32:0] mul_a;
    logic signed [31:0] mul_b;
    logic signed [64:0] mul_p;
    logic               out_free;
    logic               in_fire;
    logic               cfg_write;
    logic [47:0]        inc_sum;
    logic signed [32:0] lim_pos;
    logic signed [32:0] lim_neg;

    assign in_fire   = s_tvalid && s_tready;
    assign out_free  = !m_valid_reg || m_tready;
    assign cfg_write = psel && penable && pwrite && pready;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'd0, out_speed_reg, out_phase_reg};
    assign pready   = 1'b1;

    // Configuration port
    always_comb begin
        unique case (paddr[3:2])
            REG_PROP_GAIN:     prdata = {1'b0, prop_gain_reg};
            REG_INTEGRAL_GAIN: prdata = {1'b0, integral_gain_reg};
            REG_TIME_STEP:     prdata = {15'd0, time_step_reg};
            REG_SPEED_LIMIT:   prdata = {1'b0, speed_limit_reg};
            default:           prdata = 32'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prop_gain_reg     <= '0;
            integral_gain_reg <= '0;
            time_step_reg     <= '0;
            speed_limit_reg   <= SPEED_LIMIT_RESET;
        end else if (cfg_write) begin
            unique case (paddr[3:2])
                REG_PROP_GAIN:     prop_gain_reg     <= pwdata[30:0];
                REG_INTEGRAL_GAIN: integral_gain_reg <= pwdata[30:0];
                REG_TIME_STEP:     time_step_reg     <= pwdata[16:0];
                REG_SPEED_LIMIT:   speed_limit_reg   <= pwdata[30:0];
                default: ;
            endcase
        end
    end

    // Shared multiplier operand selection
    always_comb begin
        unique case (state_reg)
            S_MUL_KP: begin
                mul_a = {err_reg[31], err_reg};
                mul_b = {1'b0, prop_gain_reg};
            end
            S_MUL_KI: begin
                mul_a = {err_reg[31], err_reg};
                mul_b = {1'b0, integral_gain_reg};
            end
            S_MUL_PH: begin
                mul_a = {acc_reg[31], acc_reg};
                mul_b = {15'd0, time_step_reg};
            end
            S_MUL_LO: begin
                mul_a = {9'd0, prod_reg[39:16]};
                mul_b = {15'd0, time_step_reg};
            end
            S_MUL_HI: begin
                mul_a = {{9{prod_reg[63]}}, prod_reg[63:40]};
                mul_b = {15'd0, time_step_reg};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p   = mul_a * mul_b;
    // Speed increment: bits [47:16] of (ki_delta * dt), from the two partial products
    assign inc_sum = lo_reg + {prod_reg[23:0], 24'd0};
    assign lim_pos = $signed({2'b00, speed_limit_reg});
    assign lim_neg = -lim_pos;

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:     if (in_fire) state_next = S_DIFF;
            S_DIFF:     state_next = S_WRAP_ERR;
            S_WRAP_ERR: state_next = S_MUL_KP;
            S_MUL_KP:   state_next = S_SUM_SPD;
            S_SUM_SPD:  state_next = S_MUL_PH;
            S_MUL_PH:   state_next = S_SUM_PH;
            S_SUM_PH:   state_next = S_WRAP_PH;
            S_WRAP_PH:  state_next = S_MUL_KI;
            S_MUL_KI:   state_next = S_MUL_LO;
            S_MUL_LO:   state_next = S_MUL_HI;
            S_MUL_HI:   state_next = S_FORM_INC;
            S_FORM_INC: state_next = S_SUM_INC;
            S_SUM_INC:  state_next = S_CLIP;
            S_CLIP:     if (out_free) state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb begin
        acc_next       = acc_reg;
        err_next       = err_reg;
        prod_next      = prod_reg;
        lo_next        = lo_reg;
        phase_next     = phase_reg;
        speed_next     = speed_reg;
        out_phase_next = out_phase_reg;
        out_speed_next = out_speed_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        unique case (state_reg)
            S_IDLE: ;
            S_DIFF: begin
                acc_next = sat32({{14{meas_reg[18]}}, meas_reg} - {phase_reg[31], phase_reg});
            end
            S_WRAP_ERR: err_next = wrap_turn(acc_reg);
            S_MUL_KP: prod_next = mul_p[63:0];
            S_MUL_PH: prod_next = mul_p[63:0];
            S_MUL_KI: prod_next = mul_p[63:0];
            S_SUM_SPD: begin
                acc_next = sat32({speed_reg[31], speed_reg} + {prod_reg[47], prod_reg[47:16]});
            end
            S_SUM_PH: begin
                acc_next = sat32({phase_reg[31], phase_reg} + {prod_reg[47], prod_reg[47:16]});
            end
            S_WRAP_PH: phase_next = wrap_turn(acc_reg);
            // keep the low partial product, hold ki_delta in prod for the high half
            S_MUL_LO: lo_next = mul_p[47:0];
            S_MUL_HI: prod_next = mul_p[63:0];
            S_FORM_INC: acc_next = $signed(inc_sum[47:16]);
            S_SUM_INC: begin
                acc_next = sat32({speed_reg[31], speed_reg} + {acc_reg[31], acc_reg});
            end
            S_CLIP: begin
                if (out_free) begin
                    if ($signed({acc_reg[31], acc_reg}) > lim_pos) begin
                        speed_next = lim_pos[31:0];
                    end else if ($signed({acc_reg[31], acc_reg}) < lim_neg) begin
                        speed_next = lim_neg[31:0];
                    end else begin
                        speed_next = acc_reg;
                    end
                    out_phase_next = phase_reg[18:0];
                    out_speed_next = speed_next;
                    m_valid_next   = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            phase_reg   <= '0;
            speed_reg   <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            phase_reg   <= phase_next;
            speed_reg   <= speed_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            meas_reg <= $signed(s_tdata[18:0]);
        end
        acc_reg       <= acc_next;
        err_reg       <= err_next;
        prod_reg      <= prod_next;
        lo_reg        <= lo_next;
        out_phase_reg <= out_phase_next;
        out_speed_reg <= out_speed_next;
    end

    // A new item only enters an idle sequencer and is held off for its whole run
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while the sequencer was busy");

    // A finished item reaches the output register in the cycle after the clip step
    a_result_loaded: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CLIP && out_free) |=> (m_tvalid && state_reg == S_IDLE))
        else $error("clip step did not load the output register");

    // The delivered speed lies within the configured limit
    a_speed_clipped: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |->
            ($signed({out_speed_reg[31], out_speed_reg}) <= lim_pos &&
             $signed({out_speed_reg[31], out_speed_reg}) >= lim_neg))
        else $error("speed estimate outside the limit");

    // Tracked speed changes only in the clip step
    a_speed_update: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_CLIP) |=> $stable(speed_reg))
        else $error("tracked speed changed outside the clip step");

endmodule

FILE: bench/testbench.sv
// Self-checking bench for the angle tracking PLL: directed plan, then random tracking runs.
`timescale 1ns / 100ps

module testbench;
    import atpll_pkg::*;

    localparam int PLAN_ROWS  = 26;
    localparam int SEGMENTS   = 12;
    localparam int SEG_ITEMS  = 152;
    localparam int CYCLE_LIMIT = 600000;
    localparam longint I32_MAX = 64'sd2147483647;
    localparam longint I32_MIN = -64'sd2147483648;

    typedef struct packed {
        logic signed [18:0] phase;
        logic signed [31:0] speed;
    } estimate_t;

    typedef struct packed {
        bit                 is_cfg;
        logic [1:0]         reg_idx;
        logic [31:0]        value;
        logic signed [18:0] meas;
        bit                 typed;
        estimate_t          want;
    } plan_row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;    // [18:0] measured_phase, [23:19] zero
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;    // [18:0] phase_estimate, [50:19] speed_estimate, [55:51] zero
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // Loop settings and tracked state mirrored by the predictor
    logic [30:0] kp_val;
    logic [30:0] ki_val;
    logic [16:0] dt_val;
    logic [30:0] lim_val;
    int          est_phase;
    int          est_speed;

    estimate_t   pending_estimates[$];
    plan_row_t   directed_plan[PLAN_ROWS];
    int          mismatch_count;
    int          cycle_count;
    int          src_idle;
    int          snk_idle;
    int          ramp_angle;
    int          ramp_rate;

    angle_tracking_pll uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #2 aclk = ~aclk;

    function automatic int clamp32(input longint v);
        if (v > I32_MAX) begin
            return int'(I32_MAX);
        end else if (v < I32_MIN) begin
            return int'(I32_MIN);
        end
        return int'(v);
    endfunction

    function automatic int wrap_angle(input int a);
        if (a >= HALF_TURN) begin
            return a - FULL_TURN;
        end else if (a < -HALF_TURN) begin
            return a + FULL_TURN;
        end
        return a;
    endfunction

    // Advance the loop by one measured angle and return the new estimates
    function automatic estimate_t track_update(input logic signed [18:0] meas);
        longint    kp;
        longint    ki;
        longint    dt;
        longint    lim;
        longint    ki_delta;
        int        err;
        int        kp_term;
        int        spd_sum;
        int        ph_adv;
        int        spd_adv;
        int        spd;
        estimate_t est;
        kp  = kp_val;
        ki  = ki_val;
        dt  = dt_val;
        lim = lim_val;
        err = wrap_angle(clamp32(longint'(meas) - longint'(est_phase)));
        kp_term    = int'((kp * err) >>> FRAC_BITS);
        spd_sum    = clamp32(longint'(est_speed) + kp_term);
        ph_adv     = int'((longint'(spd_sum) * dt) >>> FRAC_BITS);
        est_phase  = wrap_angle(clamp32(longint'(est_phase) + ph_adv));
        // integral product stays at full width before the time step
        ki_delta  = (ki * err) >>> FRAC_BITS;
        spd_adv   = int'((ki_delta * dt) >>> FRAC_BITS);
        spd = clamp32(longint'(est_speed) + spd_adv);
        if (spd > lim) begin
            spd = int'(lim);
        end else if (spd < -lim) begin
            spd = int'(-lim);
        end
        est_speed = spd;
        est.phase = est_phase[18:0];
        est.speed = spd;
        return est;
    endfunction

    function automatic plan_row_t cfg_row(input logic [1:0] idx, input logic [31:0] value);
        plan_row_t r;
        r = '0;
        r.is_cfg  = 1'b1;
        r.reg_idx = idx;
        r.value   = value;
        return r;
    endfunction

    function automatic plan_row_t item_row(input int meas);
        plan_row_t r;
        r = '0;
        r.meas = meas[18:0];
        return r;
    endfunction

    function automatic plan_row_t known_row(input int meas, input int phase, input int speed);
        plan_row_t r;
        r = item_row(meas);
        r.typed      = 1'b1;
        r.want.phase = phase[18:0];
        r.want.speed = speed;
        return r;
    endfunction

    function automatic logic [31:0] pick_gain();
        case ($urandom_range(3))
            0: return 32'd0;
            1: return 32'h7FFF_FFFF;
            2: return $urandom_range(32'h0002_0000);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] pick_step();
        case ($urandom_range(4))
            0: return 32'd0;
            1: return 32'd65536;
            2: return 32'd131071;
            3: return $urandom_range(2048);
            default: return $urandom;
        endcase
    endfunction

    // Mostly a rotating angle with jitter, the rest uniform over range and field
    function automatic logic signed [18:0] next_phase();
        int sel;
        sel = $urandom_range(99);
        if (sel < 70) begin
            ramp_angle = ramp_angle + ramp_rate + int'($urandom_range(600)) - 300;
            while (ramp_angle >= HALF_TURN) ramp_angle = ramp_angle - FULL_TURN;
            while (ramp_angle < -HALF_TURN) ramp_angle = ramp_angle + FULL_TURN;
            return ramp_angle[18:0];
        end else if (sel < 85) begin
            sel = int'($urandom_range(411775)) - HALF_TURN;
            return sel[18:0];
        end
        sel = int'($urandom_range(19'h7FFFF));
        return sel[18:0];
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch at %0t: %s got %h expected %h", $time, what, got, want);
        mismatch_count++;
    endtask

    task automatic send_phase(input plan_row_t row);
        estimate_t est;
        @(negedge aclk);
        while ($urandom_range(99) < src_idle) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {5'b0, row.meas};
        do @(posedge aclk); while (!s_tready);
        est = track_update(row.meas);
        pending_estimates.push_back(row.typed ? row.want : est);
    endtask

    task automatic drain_results();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (pending_estimates.size() != 0) @(posedge aclk);
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [31:0] value);
        @(negedge aclk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        case (idx)
            REG_PROP_GAIN:     kp_val  = value[30:0];
            REG_INTEGRAL_GAIN: ki_val  = value[30:0];
            REG_TIME_STEP:     dt_val  = value[16:0];
            REG_SPEED_LIMIT:   lim_val = value[30:0];
            default: ;
        endcase
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= snk_idle);
    end

    always @(posedge aclk) begin
        estimate_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_estimates.size() == 0) begin
                report_mismatch("result with nothing pending", m_tdata[31:0], 32'd0);
            end else begin
                want = pending_estimates.pop_front();
                if (m_tdata[18:0] !== want.phase) begin
                    report_mismatch("phase_estimate", {13'b0, m_tdata[18:0]},
                                    {13'b0, want.phase});
                end
                if (m_tdata[50:19] !== want.speed) begin
                    report_mismatch("speed_estimate", m_tdata[50:19], want.speed);
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        int          seg;
        int          n;
        logic [31:0] cfg_word[4];
        aclk     = 1'b0;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        m_tready = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        kp_val   = '0;
        ki_val   = '0;
        dt_val   = '0;
        lim_val  = SPEED_LIMIT_RESET;
        est_phase = 0;
        est_speed = 0;
        mismatch_count = 0;
        cycle_count = 0;
        src_idle = 0;
        snk_idle = 0;
        ramp_angle = 0;
        ramp_rate = 0;

        // zero gains and time step hold both estimates at zero
        directed_plan[0]  = known_row(0, 0, 0);
        directed_plan[1]  = known_row(205887, 0, 0);
        directed_plan[2]  = known_row(-205888, 0, 0);
        directed_plan[3]  = known_row(262143, 0, 0);
        directed_plan[4]  = known_row(-262144, 0, 0);
        // full gains and a time step above one drive large phase steps
        directed_plan[5]  = cfg_row(REG_PROP_GAIN, 32'h7FFF_FFFF);
        directed_plan[6]  = cfg_row(REG_INTEGRAL_GAIN, 32'h7FFF_FFFF);
        directed_plan[7]  = cfg_row(REG_TIME_STEP, 32'd131071);
        directed_plan[8]  = item_row(205887);
        directed_plan[9]  = item_row(-262144);
        directed_plan[10] = item_row(262143);
        directed_plan[11] = item_row(0);
        directed_plan[12] = item_row(-205888);
        directed_plan[13] = item_row(1000);
        // zero limit forces the speed to zero
        directed_plan[14] = cfg_row(REG_SPEED_LIMIT, 32'd0);
        directed_plan[15] = item_row(150000);
        directed_plan[16] = item_row(-150000);
        directed_plan[17] = cfg_row(REG_PROP_GAIN, 32'h0001_0000);
        directed_plan[18] = cfg_row(REG_INTEGRAL_GAIN, 32'h0000_0400);
        directed_plan[19] = cfg_row(REG_TIME_STEP, 32'd65536);
        directed_plan[20] = cfg_row(REG_SPEED_LIMIT, 32'h0100_0000);
        directed_plan[21] = item_row(51472);
        directed_plan[22] = item_row(102944);
        directed_plan[23] = item_row(154416);
        directed_plan[24] = item_row(-205888);
        directed_plan[25] = item_row(-1);

        repeat (7) @(negedge aclk);
        aresetn = 1'b1;

        for (int i = 0; i < PLAN_ROWS; i++) begin
            if (directed_plan[i].is_cfg) begin
                drain_results();
                write_register(directed_plan[i].reg_idx, directed_plan[i].value);
            end else begin
                send_phase(directed_plan[i]);
            end
        end

        for (seg = 0; seg < SEGMENTS; seg++) begin
            drain_results();
            case (seg)
                0: cfg_word = '{32'h0001_0000, 32'h0000_0800, 32'h0000_0400, 32'h7FFF_FFFF};
                1: cfg_word = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd131071, 32'h7FFF_FFFF};
                2: cfg_word = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd65536, 32'd0};
                6: cfg_word = '{32'd0, 32'd0, 32'd0, 32'd0};
                default: begin
                    cfg_word[0] = pick_gain();
                    cfg_word[1] = pick_gain();
                    cfg_word[2] = pick_step();
                    cfg_word[3] = pick_gain();
                end
            endcase
            write_register(REG_PROP_GAIN, cfg_word[0]);
            write_register(REG_INTEGRAL_GAIN, cfg_word[1]);
            write_register(REG_TIME_STEP, cfg_word[2]);
            write_register(REG_SPEED_LIMIT, cfg_word[3]);
            if (seg < 4) begin
                src_idle = 16;
                snk_idle = 78;
            end else if (seg < 8) begin
                src_idle = 78;
                snk_idle = 16;
            end else begin
                src_idle = 0;
                snk_idle = 0;
            end
            ramp_rate = int'($urandom_range(8000)) - 4000;
            for (n = 0; n < SEG_ITEMS; n++) begin
                send_phase(item_row(int'(next_phase())));
            end
        end

        drain_results();
        repeat (32) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
